// ===== rtl/core/vlx_pkg.sv =====
package vlx_pkg;

	localparam int NumRegsDefault  = 16;
	localparam int MemWordsDefault = 1024;

	// opcodes
	localparam logic [7:0] OP_RET  = 8'h00;
	localparam logic [7:0] OP_SET  = 8'h01;
	localparam logic [7:0] OP_BEZ  = 8'h04;
	localparam logic [7:0] OP_BGTZ = 8'h05;
	localparam logic [7:0] OP_BLTZ = 8'h06;
	localparam logic [7:0] OP_LD   = 8'hC8;
	localparam logic [7:0] OP_SD   = 8'hCC;

	// arithmetic kinds, bits 3:2 of the opcode
	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;
	localparam logic [1:0] KIND_DIV = 2'd3;

	// arithmetic forms, bits 7:6 of the opcode
	localparam logic [1:0] FORM_RR = 2'd0;
	localparam logic [1:0] FORM_RI = 2'd1;
	localparam logic [1:0] FORM_II = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_DIVZERO = 3'd2;
	localparam logic [2:0] ST_BADREG  = 3'd3;
	localparam logic [2:0] ST_BADADDR = 3'd4;
	localparam logic [2:0] ST_HALTED  = 3'd5;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DIV,
		S_DONE,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;   // write zero at clear pointer
		logic latch_in;   // capture input word
		logic read_ops;   // capture operands
		logic exec;       // evaluate and form result
		logic div_start;
		logic div_step;
		logic div_finish; // take quotient or load data into result
		logic commit;     // write back register or memory
		logic out_take;   // output consumed
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic need_div;
		logic div_last;
		logic need_mem;
	} sts_t;

endpackage

// ===== rtl/core/vlx_ctrl.sv =====
module vlx_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  vlx_pkg::sts_t sts,
	output vlx_pkg::ctl_t ctl
);
	import vlx_pkg::*;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.latch_in = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				ctl.read_ops = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				if (sts.need_div) begin
					ctl.div_start = 1'b1;
					state_d = S_DIV;
				end else if (sts.need_mem) begin
					state_d = S_DONE;
				end else begin
					ctl.commit = 1'b1;
					state_d = S_OUT;
				end
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last) state_d = S_DONE;
			end
			S_DONE: begin
				ctl.div_finish = 1'b1;
				ctl.commit = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					ctl.out_take = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

`ifndef SYNTH
	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> state_q == S_OUT) else $error("commit did not lead to output");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("output dropped");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_READ) else $error("accept lost");
`endif

endmodule

// ===== rtl/core/vlx_dpath.sv =====
module vlx_dpath #(
	parameter int NUM_REGS  = vlx_pkg::NumRegsDefault,
	parameter int MEM_WORDS = vlx_pkg::MemWordsDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  vlx_pkg::ctl_t ctl,
	output vlx_pkg::sts_t sts,
	input  logic [7:0]    op,
	input  logic [7:0]    byte_one,
	input  logic [7:0]    byte_two,
	input  logic [7:0]    byte_three,
	input  logic [7:0]    byte_four,
	input  logic [7:0]    byte_five,
	output logic          reg_write,
	output logic [3:0]    reg_index,
	output logic signed [31:0] reg_value,
	output logic          branch_taken,
	output logic [15:0]   branch_target,
	output logic          store_valid,
	output logic [9:0]    store_addr,
	output logic signed [31:0] store_data,
	output logic [2:0]    status,
	output logic          halt
);
	import vlx_pkg::*;

	localparam int RW = (NUM_REGS > 2) ? $clog2(NUM_REGS) : 1;
	localparam int AW = $clog2(MEM_WORDS);

	logic [31:0] rf_q [NUM_REGS];
	logic [31:0] mem [MEM_WORDS];
	logic [AW:0] clr_ptr_q;
	logic        halted_q;

	logic [7:0]  op_q, b1_q, b2_q, b3_q, b4_q, b5_q;
	logic [31:0] x_q, y_q, v1_q;
	logic [31:0] mem_rd_q;

	// result registers
	logic        wr_q, br_q, st_q;
	logic [7:0]  widx_q;
	logic [31:0] wval_q, sdata_q;
	logic [15:0] btgt_q;
	logic [AW-1:0] saddr_q;
	logic [2:0]  status_q;
	logic        negq_q;

	// divider
	logic [31:0] dq_q, drem_q, dden_q;
	logic [4:0]  dcnt_q;

	// decode
	logic [1:0] form, kind;
	logic       is_arith, b1_bad, b2_bad, b3_bad;
	assign form     = op_q[7:6];
	assign kind     = op_q[3:2];
	assign is_arith = ((op_q & 8'h33) == 8'h10) && (form != 2'd3);
	assign b1_bad   = {24'd0, b1_q} >= NUM_REGS;
	assign b2_bad   = {24'd0, b2_q} >= NUM_REGS;
	assign b3_bad   = {24'd0, b3_q} >= NUM_REGS;

	logic [RW-1:0] i1, i2, i3;
	assign i1 = b1_q[RW-1:0];
	assign i2 = b2_q[RW-1:0];
	assign i3 = b3_q[RW-1:0];

	// input word capture
	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			op_q <= op; b1_q <= byte_one; b2_q <= byte_two;
			b3_q <= byte_three; b4_q <= byte_four; b5_q <= byte_five;
		end
	end

	// operand fetch, lookup is guarded by the bad index checks
	always_ff @(posedge clk) begin
		if (ctl.read_ops) begin
			v1_q <= b1_bad ? 32'd0 : rf_q[i1];
			if (form == FORM_II && op_q != OP_LD && op_q != OP_SD) x_q <= {16'd0, b2_q, b3_q};
			else x_q <= b2_bad ? 32'd0 : rf_q[i2];
			if (form == FORM_RR) y_q <= b3_bad ? 32'd0 : rf_q[i3];
			else if (form == FORM_RI) y_q <= {16'd0, b3_q, b4_q};
			else y_q <= {16'd0, b4_q, b5_q};
		end
	end

	// status evaluation
	logic        e_wr, e_br, e_st, e_div, e_mem, e_sgn, e_halt;
	logic [2:0]  e_status;
	logic [31:0] e_val, e_prod;

	// memory: clear sweep, read for load, write on store commit
	logic [31:0] addr_full;
	assign addr_full = x_q;
	always_ff @(posedge clk) begin
		if (ctl.clr_step) mem[clr_ptr_q[AW-1:0]] <= '0;
		else if (ctl.commit && ctl.exec && e_st) mem[x_q[AW-1:0]] <= v1_q;
		mem_rd_q <= mem[addr_full[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_ptr_q <= '0;
		else if (ctl.clr_step) clr_ptr_q <= clr_ptr_q + 1'b1;
	end
	assign sts.clr_last = clr_ptr_q == (AW+1)'(MEM_WORDS - 1);

	assign e_prod = x_q * y_q;
	always_comb begin
		e_wr = 1'b0; e_br = 1'b0; e_st = 1'b0; e_div = 1'b0; e_mem = 1'b0;
		e_sgn = 1'b0; e_halt = 1'b0; e_status = ST_OK; e_val = '0;
		if (halted_q) e_status = ST_HALTED;
		else if (op_q == OP_RET) e_halt = 1'b1;
		else if (op_q == OP_SET) begin
			if (b1_bad) e_status = ST_BADREG;
			else begin e_wr = 1'b1; e_val = {16'd0, b2_q, b3_q}; end
		end else if (is_arith) begin
			if (b1_bad || (form == FORM_RR && (b2_bad || b3_bad)) ||
				(form == FORM_RI && b2_bad)) e_status = ST_BADREG;
			else begin
				case (kind)
					KIND_ADD: begin e_wr = 1'b1; e_val = x_q + y_q; end
					KIND_SUB: begin e_wr = 1'b1; e_val = x_q - y_q; end
					KIND_MUL: begin e_wr = 1'b1; e_val = e_prod; end
					default: begin
						if (y_q == 32'd0) e_status = ST_DIVZERO;
						else begin e_wr = 1'b1; e_div = 1'b1; e_sgn = form == FORM_RR; end
					end
				endcase
			end
		end else if (op_q == OP_BEZ || op_q == OP_BGTZ || op_q == OP_BLTZ) begin
			if (b1_bad) e_status = ST_BADREG;
			else if ((op_q == OP_BEZ && v1_q == 32'd0) ||
				(op_q == OP_BGTZ && v1_q != 32'd0 && !v1_q[31]) ||
				(op_q == OP_BLTZ && v1_q[31])) e_br = 1'b1;
		end else if (op_q == OP_LD || op_q == OP_SD) begin
			if (b1_bad || b2_bad) e_status = ST_BADREG;
			else if (x_q >= MEM_WORDS) e_status = ST_BADADDR;
			else if (op_q == OP_LD) begin e_wr = 1'b1; e_mem = 1'b1; end
			else e_st = 1'b1;
		end else e_status = ST_INVALID;
	end
	assign sts.need_div = e_div;
	assign sts.need_mem = e_mem;

	logic [31:0] xa, ya;
	assign xa = (e_sgn && x_q[31]) ? 32'd0 - x_q : x_q;
	assign ya = (e_sgn && y_q[31]) ? 32'd0 - y_q : y_q;

	// restoring divider, one quotient bit per cycle
	logic [32:0] trial;
	assign trial = {drem_q, dq_q[31]} - {1'b0, dden_q};
	assign sts.div_last = dcnt_q == 5'd31;
	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			dq_q <= xa; drem_q <= '0; dden_q <= ya; dcnt_q <= '0;
			negq_q <= e_sgn && (x_q[31] != y_q[31]);
		end else if (ctl.div_step) begin
			dcnt_q <= dcnt_q + 1'b1;
			if (!trial[32]) begin
				drem_q <= trial[31:0]; dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				drem_q <= {drem_q[30:0], dq_q[31]}; dq_q <= {dq_q[30:0], 1'b0};
			end
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			wr_q <= e_wr; br_q <= e_br; st_q <= e_st; status_q <= e_status;
			widx_q <= e_wr ? b1_q : 8'd0;
			wval_q <= e_val;
			btgt_q <= e_br ? {b2_q, b3_q} : 16'd0;
			saddr_q <= e_st ? x_q[AW-1:0] : '0;
			sdata_q <= e_st ? v1_q : 32'd0;
		end else if (ctl.div_finish) begin
			if (op_q == OP_LD) wval_q <= mem_rd_q;
			else wval_q <= negq_q ? 32'd0 - dq_q : dq_q;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= '0;
		end else begin
			if (ctl.exec && e_halt) halted_q <= 1'b1;
			if (ctl.commit) begin
				if (ctl.exec) begin
					if (e_wr) rf_q[i1] <= e_val;
				end else if (wr_q) begin
					rf_q[widx_q[RW-1:0]] <= (op_q == OP_LD) ? mem_rd_q :
						(negq_q ? 32'd0 - dq_q : dq_q);
				end
			end
		end
	end

	assign reg_write     = wr_q;
	assign reg_index     = widx_q[3:0];
	assign reg_value     = wval_q;
	assign branch_taken  = br_q;
	assign branch_target = btgt_q;
	assign store_valid   = st_q;
	assign store_addr    = 10'(saddr_q);
	assign store_data    = sdata_q;
	assign status        = status_q;
	assign halt          = halted_q;

`ifndef SYNTH
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_start |-> y_q != 32'd0) else $error("divide started by zero");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(halted_q) |-> halted_q) else $error("halt cleared");
	a_store_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit && st_q |-> status_q == ST_OK) else $error("store with bad status");
`endif

endmodule

// ===== rtl/core/variable_length_isa_execute_unit_top.sv =====
// Executes one instruction word per item and returns one result word. After reset
// the data memory is cleared one word per cycle, every word, with input
// stalled. A normal instruction passes capture, register read, execute and output;
// a load adds a done state for the memory read port; a divide runs the 32-step
// restoring divider and then the done state. One item is in flight.
module variable_length_isa_execute_unit_top #(
	parameter int NUM_REGS  = vlx_pkg::NumRegsDefault,
	parameter int MEM_WORDS = vlx_pkg::MemWordsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  op,
	input  logic [7:0]  byte_one,
	input  logic [7:0]  byte_two,
	input  logic [7:0]  byte_three,
	input  logic [7:0]  byte_four,
	input  logic [7:0]  byte_five,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        reg_write,
	output logic [3:0]  reg_index,
	output logic signed [31:0] reg_value,
	output logic        branch_taken,
	output logic [15:0] branch_target,
	output logic        store_valid,
	output logic [9:0]  store_addr,
	output logic signed [31:0] store_data,
	output logic [2:0]  status,
	output logic        halt
);
	import vlx_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencer
	vlx_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .ctl(ctl)
	);

	// execution datapath
	vlx_dpath #(.NUM_REGS(NUM_REGS), .MEM_WORDS(MEM_WORDS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.op(op), .byte_one(byte_one), .byte_two(byte_two), .byte_three(byte_three),
		.byte_four(byte_four), .byte_five(byte_five),
		.reg_write(reg_write), .reg_index(reg_index), .reg_value(reg_value),
		.branch_taken(branch_taken), .branch_target(branch_target),
		.store_valid(store_valid), .store_addr(store_addr), .store_data(store_data),
		.status(status), .halt(halt)
	);

endmodule
